// File: hdl/stack_graph_traversal_core_macros.svh
// Assertion macros used by the checker file of the traversal core.
`ifndef STACK_GRAPH_TRAVERSAL_CORE_MACROS_SVH
`define STACK_GRAPH_TRAVERSAL_CORE_MACROS_SVH

// Same-cycle implication under the core clock and reset.
`define SGT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication under the core clock and reset.
`define SGT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: hdl/sgt_pkg.sv
// Shared constants, codes and controller/datapath interface types of the traversal core.
package sgt_pkg;

  // Graph size and field widths.
  localparam int MaxNodes = 16;
  localparam int NodeW    = 4;
  localparam int CountW   = 5;
  localparam int RowW     = 16;

  // Input command codes.
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdRun  = 1'b1;

  // Configuration register indexes.
  localparam logic RegNodeCount = 1'b0;
  localparam logic RegStartNode = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic error;
    logic run_init;
    logic scan;
    logic pop;
    logic finish;
  } sgt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_bad;
    logic scan_last;
    logic stack_empty;
    logic count_full;
    logic done_on_pop;
  } sgt_status_t;

endpackage

// File: hdl/stack_graph_traversal_core.sv
// Top level of the depth-first graph traversal core.
//
// A load beat (command 0) writes one adjacency row and gives no result. A run
// beat (command 1) clears the visited map, visits the start node and then scans
// the current node's row one neighbor per cycle over the n nodes in use, pushing
// unvisited neighbors, followed by a step that pops the next node. The node popped
// last is not scanned when that pop reaches every node in use. Each visited node
// shows on the result ports for exactly one cycle, marked by result_valid_o, and
// the receiver cannot hold it off. The final result of a run has last_visit_o set
// and all_reached_o telling whether every node in use was visited. A start node
// not below node_count gives one error result the cycle after the beat, with busy
// staying low. Configuration writes are taken while busy is low.
module stack_graph_traversal_core import sgt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              command_i,
  input  logic [NodeW-1:0]  row_index_i,
  input  logic [RowW-1:0]   row_bits_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [CountW-1:0] cfg_data_i,
  output logic              result_valid_o,
  output logic [NodeW-1:0]  visited_node_o,
  output logic              last_visit_o,
  output logic              all_reached_o,
  output logic              start_invalid_o
);

  sgt_cmd_t    cmd;
  sgt_status_t status;
  logic        busy_w;

  assign busy        = busy_w;
  assign cfg_ready_o = ~busy_w;

  // Sequencing.
  sgt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy_w)
  );

  // Storage and result registers.
  sgt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_valid_i & ~busy_w),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .row_index_i     (row_index_i),
    .row_bits_i      (row_bits_i),
    .result_valid_o  (result_valid_o),
    .visited_node_o  (visited_node_o),
    .last_visit_o    (last_visit_o),
    .all_reached_o   (all_reached_o),
    .start_invalid_o (start_invalid_o)
  );

endmodule

// File: hdl/sgt_ctrl.sv
// Controller state machine that sequences loads, neighbor scans and stack pops.
module sgt_ctrl import sgt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        command_i,
  input  sgt_status_t status_i,
  output sgt_cmd_t    cmd_o,
  output logic        busy_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDecide,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  // Next state and datapath commands.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          if (command_i == CmdLoad) begin
            cmd_o.load = 1'b1;
          end else if (status_i.start_bad) begin
            cmd_o.error = 1'b1;
          end else begin
            cmd_o.run_init = 1'b1;
            state_d        = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (status_i.stack_empty || status_i.count_full) begin
          state_d = StFinish;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = status_i.done_on_pop ? StFinish : StScan;
        end
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and the registered busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != StIdle);
    end
  end

  assign busy_o = busy_q;

endmodule

// File: hdl/sgt_datapath.sv
// Datapath: adjacency rows, visited map, node stack, scan counter and result registers.
module sgt_datapath import sgt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgt_cmd_t          cmd_i,
  output sgt_status_t       status_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [CountW-1:0] cfg_data_i,
  input  logic [NodeW-1:0]  row_index_i,
  input  logic [RowW-1:0]   row_bits_i,
  output logic              result_valid_o,
  output logic [NodeW-1:0]  visited_node_o,
  output logic              last_visit_o,
  output logic              all_reached_o,
  output logic              start_invalid_o
);

  logic [CountW-1:0] node_count_q;
  logic [NodeW-1:0]  start_node_q;

  logic [RowW-1:0]   adj_q [MaxNodes];
  logic [NodeW-1:0]  stack_q [MaxNodes];
  logic [RowW-1:0]   visited_q;
  logic [CountW-1:0] depth_q;
  logic [NodeW-1:0]  cur_q;
  logic [CountW-1:0] count_q;
  logic [NodeW-1:0]  scan_q;

  logic              valid_q;
  logic [NodeW-1:0]  node_q;
  logic              last_q;
  logic              all_q;
  logic              bad_q;

  logic [CountW-1:0] node_lim;
  logic [RowW-1:0]   full_mask;
  logic              all_hit;
  logic [RowW-1:0]   cur_row;
  logic              cand;
  logic [NodeW-1:0]  top_idx;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountW'(MaxNodes);
      start_node_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegNodeCount: node_count_q <= cfg_data_i;
        RegStartNode: start_node_q <= cfg_data_i[NodeW-1:0];
        default: ;
      endcase
    end
  end

  // Node count saturated to the store size, and the mask of nodes in use.
  assign node_lim = (node_count_q > CountW'(MaxNodes)) ? CountW'(MaxNodes) : node_count_q;

  always_comb begin
    for (int i = 0; i < RowW; i++) begin
      full_mask[i] = (CountW'(i) < node_lim);
    end
  end

  assign all_hit = ((visited_q & full_mask) == full_mask);

  // A neighbor is pushed when it has an edge, is unvisited and the stack has room.
  assign cur_row = adj_q[cur_q];
  assign cand    = cur_row[scan_q] & ~visited_q[scan_q] & ~depth_q[CountW-1];
  assign top_idx = depth_q[NodeW-1:0] - 1'b1;

  // Status toward the controller.
  assign status_o.start_bad   = ({1'b0, start_node_q} >= node_lim);
  assign status_o.scan_last   = ({1'b0, scan_q} == (node_lim - 1'b1));
  assign status_o.stack_empty = (depth_q == '0);
  assign status_o.count_full  = (count_q == CountW'(MaxNodes));
  assign status_o.done_on_pop = all_hit && (depth_q == CountW'(1));

  // Adjacency rows and stack entries carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      adj_q[row_index_i] <= row_bits_i;
    end
    if (cmd_i.scan && cand) begin
      stack_q[depth_q[NodeW-1:0]] <= scan_q;
    end
  end

  // Traversal state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      depth_q   <= '0;
      cur_q     <= '0;
      count_q   <= '0;
      scan_q    <= '0;
    end else if (cmd_i.run_init) begin
      visited_q <= RowW'(1) << start_node_q;
      depth_q   <= '0;
      cur_q     <= start_node_q;
      count_q   <= CountW'(1);
      scan_q    <= '0;
    end else if (cmd_i.scan) begin
      scan_q <= scan_q + 1'b1;
      if (cand) begin
        visited_q[scan_q] <= 1'b1;
        depth_q           <= depth_q + 1'b1;
      end
    end else if (cmd_i.pop) begin
      cur_q   <= stack_q[top_idx];
      depth_q <= depth_q - 1'b1;
      count_q <= count_q + 1'b1;
      scan_q  <= '0;
    end
  end

  // Result strobe. The current node is held back until it is known whether it is last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.error | cmd_i.pop | cmd_i.finish;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.error) begin
      node_q <= '0;
      last_q <= 1'b1;
      all_q  <= 1'b0;
      bad_q  <= 1'b1;
    end else if (cmd_i.pop) begin
      node_q <= cur_q;
      last_q <= 1'b0;
      all_q  <= 1'b0;
      bad_q  <= 1'b0;
    end else if (cmd_i.finish) begin
      node_q <= cur_q;
      last_q <= 1'b1;
      all_q  <= all_hit;
      bad_q  <= 1'b0;
    end
  end

  assign result_valid_o  = valid_q;
  assign visited_node_o  = node_q;
  assign last_visit_o    = last_q;
  assign all_reached_o   = all_q;
  assign start_invalid_o = bad_q;

endmodule

// File: hdl/sgt_checker.sv
// Port-level checker of the traversal core and its bind statement.
`include "stack_graph_traversal_core_macros.svh"

module sgt_checker import sgt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             command_i,
  input logic             result_valid_o,
  input logic [NodeW-1:0] visited_node_o,
  input logic             last_visit_o,
  input logic             all_reached_o,
  input logic             start_invalid_o
);

  // An error result is a single final result for node zero.
  `SGT_ASSERT_IMPLY(a_error_shape, clk_i, rst_ni, result_valid_o && start_invalid_o, last_visit_o && !all_reached_o && (visited_node_o == '0))

  // The reached flag only appears on the final result of a run.
  `SGT_ASSERT_IMPLY(a_reached_on_last, clk_i, rst_ni, result_valid_o && all_reached_o, last_visit_o)

  // The core is free again once the final result shows.
  `SGT_ASSERT_IMPLY(a_idle_after_last, clk_i, rst_ni, result_valid_o && last_visit_o, !busy)

  // A run beat either starts a traversal or answers with an error at once.
  `SGT_ASSERT_NEXT(a_run_response, clk_i, rst_ni, start && !busy && (command_i == CmdRun), busy || (result_valid_o && start_invalid_o))

  // A load beat gives no result and leaves the core idle.
  `SGT_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, start && !busy && (command_i == CmdLoad), !busy && !result_valid_o)

endmodule

bind stack_graph_traversal_core sgt_checker u_sgt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .command_i       (command_i),
  .result_valid_o  (result_valid_o),
  .visited_node_o  (visited_node_o),
  .last_visit_o    (last_visit_o),
  .all_reached_o   (all_reached_o),
  .start_invalid_o (start_invalid_o)
);

// File: sim/tb.sv
// Self-checking testbench for the depth-first graph traversal core.
module tb;
  import sgt_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int RandomBeats  = 387;
  localparam int SettleCycles = 4;

  // One visit as it shows on the result ports.
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic             last_visit;
    logic             all_reached;
    logic             start_invalid;
  } visit_t;

  // Tracks the graph and registers, predicts the visit order of each run and
  // checks the visits that come out of the core.
  class traversal_scoreboard;
    logic [RowW-1:0]   adj_rows [MaxNodes];
    logic [CountW-1:0] node_count;
    logic [NodeW-1:0]  start_node;
    visit_t            visits_due [$];
    int                errors;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      node_count = CountW'(MaxNodes);
      start_node = '0;
      errors     = 0;
    endfunction

    function void write_register(logic idx, logic [CountW-1:0] data);
      if (idx == RegNodeCount) begin
        node_count = data;
      end else begin
        start_node = data[NodeW-1:0];
      end
    endfunction

    // Notes an accepted beat and queues the visits it causes.
    function void note_beat(logic cmd, logic [NodeW-1:0] row, logic [RowW-1:0] bits);
      int               n;
      int               depth;
      int               count;
      int               x;
      int               k;
      logic [RowW:0]    wide;
      logic [RowW-1:0]  full;
      logic [RowW-1:0]  seen;
      logic [RowW-1:0]  nb;
      logic [NodeW-1:0] cur;
      logic [NodeW-1:0] pending [MaxNodes];
      logic [NodeW-1:0] order [MaxNodes];
      visit_t           v;

      if (cmd == CmdLoad) begin
        adj_rows[row] = bits;
        return;
      end

      n = (node_count > MaxNodes) ? MaxNodes : int'(node_count);

      // A start node outside the graph gives a lone error visit.
      if (int'(start_node) >= n) begin
        v.node          = '0;
        v.last_visit    = 1'b1;
        v.all_reached   = 1'b0;
        v.start_invalid = 1'b1;
        visits_due.push_back(v);
        return;
      end

      wide = (17'd1 << n) - 17'd1;
      full = wide[RowW-1:0];
      seen = '0;
      seen[start_node] = 1'b1;
      depth = 0;
      cur = start_node;
      order[0] = cur;
      count = 1;

      // Push unvisited neighbors in ascending order, then pop the top.
      while (1) begin
        nb = adj_rows[cur];
        for (x = 0; x < n; x++) begin
          if (nb[x] && !seen[x] && depth < MaxNodes) begin
            seen[x] = 1'b1;
            pending[depth] = NodeW'(x);
            depth++;
          end
        end
        if (depth == 0 || count >= MaxNodes) break;
        depth--;
        cur = pending[depth];
        order[count] = cur;
        count++;
        if ((seen & full) == full && depth == 0) break;
      end

      for (k = 0; k < count; k++) begin
        v.node          = order[k];
        v.last_visit    = (k == count - 1);
        v.all_reached   = v.last_visit && ((seen & full) == full);
        v.start_invalid = 1'b0;
        visits_due.push_back(v);
      end
    endfunction

    function void compare_field(string name, logic [NodeW-1:0] want, logic [NodeW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Checks one visit against the oldest one still due.
    function void check_visit(visit_t got);
      visit_t want;
      if (visits_due.size() == 0) begin
        $display("%0t: unexpected visit, expected none, actual node %0d last %0b all %0b bad %0b",
                 $time, got.node, got.last_visit, got.all_reached, got.start_invalid);
        errors++;
        return;
      end
      want = visits_due.pop_front();
      compare_field("visited_node", want.node, got.node);
      compare_field("last_visit", NodeW'(want.last_visit), NodeW'(got.last_visit));
      compare_field("all_reached", NodeW'(want.all_reached), NodeW'(got.all_reached));
      compare_field("start_invalid", NodeW'(want.start_invalid), NodeW'(got.start_invalid));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              command_i;
  logic [NodeW-1:0]  row_index_i;
  logic [RowW-1:0]   row_bits_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              cfg_index_i;
  logic [CountW-1:0] cfg_data_i;
  logic              result_valid_o;
  logic [NodeW-1:0]  visited_node_o;
  logic              last_visit_o;
  logic              all_reached_o;
  logic              start_invalid_o;

  traversal_scoreboard sb;
  bit eager;
  int stall_cycles = 0;

  stack_graph_traversal_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .row_index_i     (row_index_i),
    .row_bits_i      (row_bits_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .visited_node_o  (visited_node_o),
    .last_visit_o    (last_visit_o),
    .all_reached_o   (all_reached_o),
    .start_invalid_o (start_invalid_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Every visit strobe is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_visit({visited_node_o, last_visit_o, all_reached_o, start_invalid_o});
    end
  end

  // Ends a run that stops making progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offers one command beat after a random gap and waits for it to be taken.
  task automatic send_beat(input logic cmd, input logic [NodeW-1:0] row,
                           input logic [RowW-1:0] bits);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    command_i   <= cmd;
    row_index_i <= row;
    row_bits_i  <= bits;
    do @(posedge clk_i); while (busy);
    sb.note_beat(cmd, row, bits);
  endtask

  // Stops sending and waits until every visit has come and the core is idle.
  task automatic drain();
    start <= 1'b0;
    while (sb.visits_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CountW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // Adjacency rows of several shapes: random, sparse, chained, empty and dense.
  function automatic logic [RowW-1:0] random_row(input logic [NodeW-1:0] row);
    logic [RowW-1:0] bits;
    case ($urandom_range(0, 5))
      0: bits = RowW'($urandom);
      1: bits = RowW'(1) << $urandom_range(0, 15);
      2: bits = (RowW'(1) << $urandom_range(0, 15)) | (RowW'(1) << $urandom_range(0, 15));
      3: bits = (RowW'(1) << NodeW'(row + 4'd1)) | RowW'($urandom & $urandom & $urandom);
      4: bits = '0;
      default: bits = ~(RowW'(1) << $urandom_range(0, 15));
    endcase
    return bits;
  endfunction

  initial begin
    int              items_sent;
    int              burst;
    int              cnt;
    int              eff;
    int              st;
    int              r;
    logic [RowW-1:0] bits;

    sb = new();
    eager = 1'b0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    command_i   <= CmdLoad;
    row_index_i <= '0;
    row_bits_i  <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= RegNodeCount;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every row first: a full row, a self loop, an empty row and chains.
    for (r = 0; r < MaxNodes; r++) begin
      if (r == 0) bits = 16'hFFFF;
      else if (r == MaxNodes - 1) bits = 16'h8000;
      else if (r == 7) bits = 16'h0000;
      else bits = (RowW'(1) << (r + 1)) | (RowW'(1) << (r - 1));
      send_beat(CmdLoad, NodeW'(r), bits);
    end

    // Run with the registers as they come out of reset.
    send_beat(CmdRun, '0, '0);

    // A single node graph.
    write_reg(RegNodeCount, 5'd1);
    write_reg(RegStartNode, 5'd0);
    send_beat(CmdRun, 4'hF, 16'hFFFF);

    // Start node equal to the node count is rejected.
    write_reg(RegStartNode, 5'd1);
    send_beat(CmdRun, '0, '0);

    // Two nodes; row bits above the node count are ignored.
    write_reg(RegNodeCount, 5'd2);
    send_beat(CmdRun, '0, '0);

    // A node count of zero rejects every start node.
    write_reg(RegNodeCount, 5'd0);
    send_beat(CmdRun, '0, '0);

    // Node count above the store saturates; highest start node on a self loop.
    write_reg(RegNodeCount, 5'd31);
    write_reg(RegStartNode, 5'd15);
    send_beat(CmdRun, '0, '0);

    // Full graph from a middle node, with the spare data bit set.
    write_reg(RegNodeCount, 5'd16);
    write_reg(RegStartNode, 5'h15);
    send_beat(CmdRun, '0, '0);

    // Random phases: pick a graph size and start, then mix loads and runs.
    items_sent = 0;
    while (items_sent < RandomBeats) begin
      eager = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        cnt = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
      end else if ($urandom_range(0, 1) == 0) begin
        cnt = $urandom_range(1, 6);
      end else begin
        cnt = $urandom_range(1, 16);
      end
      eff = (cnt > MaxNodes) ? MaxNodes : cnt;
      if (eff > 0 && $urandom_range(0, 5) != 0) begin
        st = $urandom_range(0, eff - 1);
      end else begin
        st = $urandom_range(0, 15);
      end
      write_reg(RegNodeCount, CountW'(cnt));
      write_reg(RegStartNode, {1'($urandom_range(0, 1)), NodeW'(st)});

      burst = $urandom_range(3, 12);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 4) begin
          r = (eff > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, eff - 1)
                                                     : $urandom_range(0, 15);
          send_beat(CmdLoad, NodeW'(r), random_row(NodeW'(r)));
        end else begin
          send_beat(CmdRun, NodeW'($urandom_range(0, 15)), RowW'($urandom));
        end
        items_sent++;
        // Now and then hold off until the core has caught up.
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    // Let the last visits arrive, then give the core time to go quiet.
    start <= 1'b0;
    while (sb.visits_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.visits_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
